@@ rtl/core/ntchtp_pkg.sv @@
package ntchtp_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned SumW    = 12;
  localparam int unsigned CntW    = 6;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [IdxW-1:0] LastIndex = IdxW'(10);   // eleventh word of a group
  localparam int unsigned     MeanShift = 3;

  localparam logic [CntW-1:0] TicksPerSecond   = CntW'(50);
  localparam logic [CntW-1:0] SecondsPerMinute = CntW'(60);
  localparam logic [CntW-1:0] MinutesPerHour   = CntW'(60);

  localparam logic [1:0] StIdle    = 2'd0;
  localparam logic [1:0] StHeat    = 2'd1;
  localparam logic [1:0] StBan     = 2'd2;
  localparam logic [1:0] StBanExit = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgErrorHigh = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgErrorLow  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgHeatOn    = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgHeatOff   = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CfgOverheat  = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] CfgCooled    = CfgIdxW'(5);

endpackage

@@ rtl/core/ntc_heater_thermostat_protect_unit.sv @@
// Thermostat with overheat lockout for an NTC sensor. One eight-bit ADC sample is
// taken per input word and the block can accept one every clock cycle. Samples come
// in groups of eleven: the first is dropped, the other ten are summed and trimmed of
// their maximum and minimum, and the sum over eight gives the reading. Each reading
// yields one output word: the reading is registered, then thermostat, fault window
// and the one-hour lockout timer apply as it moves to the output. Input stalls only
// while a reading waits behind an output word that is not taken. The user must write
// thresholds through the cfg port while the block is idle; the block does not check.
module ntc_heater_thermostat_protect_unit
  import ntchtp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] adc_sample
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata    // [7:0] reading, [8] heater_on,
                                             // [10:9] status, [11] protecting, rest 0
);

  logic [7:0] err_hi_q, err_lo_q, heat_on_q, heat_off_q, overheat_q, cooled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_hi_q   <= 8'd250;
      err_lo_q   <= 8'd5;
      heat_on_q  <= 8'd150;
      heat_off_q <= 8'd130;
      overheat_q <= 8'd80;
      cooled_q   <= 8'd90;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgErrorHigh: err_hi_q   <= cfg_wdata_i;
        CfgErrorLow:  err_lo_q   <= cfg_wdata_i;
        CfgHeatOn:    heat_on_q  <= cfg_wdata_i;
        CfgHeatOff:   heat_off_q <= cfg_wdata_i;
        CfgOverheat:  overheat_q <= cfg_wdata_i;
        CfgCooled:    cooled_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake between the stages.
  logic out_free, s_acc, rd_move;
  logic rd_vld_q;
  logic out_vld_q;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign rd_move       = rd_vld_q && out_free;
  assign s_axis_tready = !rd_vld_q || out_free;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Group accumulation, done as each word is accepted.
  logic [IdxW-1:0]    idx_q;
  logic [SampleW-1:0] max_q, min_q, max_n, min_n;
  logic [SumW-1:0]    sum_q, sum_n, trimmed;
  logic [SampleW-1:0] rd_q;

  always_comb begin
    max_n = max_q;
    min_n = min_q;
    sum_n = sum_q;
    if (idx_q != '0) begin
      if (s_axis_tdata > max_q) max_n = s_axis_tdata;
      if (s_axis_tdata < min_q) min_n = s_axis_tdata;
      sum_n = sum_q + SumW'(s_axis_tdata);
    end
    trimmed = sum_n - (SumW'(max_n) + SumW'(min_n));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      max_q    <= '0;
      min_q    <= '1;
      sum_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (rd_move) rd_vld_q <= 1'b0;
      if (s_acc) begin
        if (idx_q == LastIndex) begin
          idx_q    <= '0;
          max_q    <= '0;
          min_q    <= '1;
          sum_q    <= '0;
          rd_vld_q <= 1'b1;
        end else begin
          idx_q <= idx_q + IdxW'(1);
          max_q <= max_n;
          min_q <= min_n;
          sum_q <= sum_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && idx_q == LastIndex) rd_q <= SampleW'(trimmed >> MeanShift);
  end

  // Thermostat and lockout update for one reading.
  logic            heater_q, heater_d, lock_q, lock_d, restart_q, restart_d;
  logic [1:0]      status_q, status_d;
  logic [CntW-1:0] tick_q, tick_d, sec_q, sec_d, min_cnt_q, min_cnt_d;

  always_comb begin
    heater_d  = heater_q;
    status_d  = status_q;
    lock_d    = lock_q;
    restart_d = restart_q;
    tick_d    = tick_q;
    sec_d     = sec_q;
    min_cnt_d = min_cnt_q;
    if (rd_q > err_hi_q || rd_q < err_lo_q) begin
      heater_d = 1'b0;
      status_d = StIdle;
    end else begin
      if (!lock_q) begin
        if (rd_q > heat_on_q) begin
          heater_d = 1'b1;
          status_d = StHeat;
        end
        if (rd_q < heat_off_q) begin
          heater_d = 1'b0;
          status_d = StIdle;
        end
      end
      if (rd_q < overheat_q) begin
        status_d = StBan;
        heater_d = 1'b0;
        if (!lock_q) begin
          lock_d    = 1'b1;
          restart_d = 1'b1;
        end
      end
      if (lock_d) begin
        // A pending restart zeroes the timer before this reading is counted.
        if (restart_d) begin
          restart_d = 1'b0;
          tick_d    = '0;
          sec_d     = '0;
          min_cnt_d = '0;
        end
        tick_d = tick_d + CntW'(1);
        if (tick_d >= TicksPerSecond) begin
          tick_d = '0;
          sec_d  = sec_d + CntW'(1);
          if (sec_d >= SecondsPerMinute) begin
            sec_d     = '0;
            min_cnt_d = min_cnt_d + CntW'(1);
            if (min_cnt_d >= MinutesPerHour) begin
              min_cnt_d = '0;
              if (rd_q < cooled_q) begin
                restart_d = 1'b1;
              end else begin
                lock_d   = 1'b0;
                status_d = StBanExit;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heater_q  <= 1'b0;
      status_q  <= StIdle;
      lock_q    <= 1'b0;
      restart_q <= 1'b0;
      tick_q    <= '0;
      sec_q     <= '0;
      min_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_free) out_vld_q <= rd_move;
      if (rd_move) begin
        heater_q  <= heater_d;
        status_q  <= status_d;
        lock_q    <= lock_d;
        restart_q <= restart_d;
        tick_q    <= tick_d;
        sec_q     <= sec_d;
        min_cnt_q <= min_cnt_d;
      end
    end
  end

  logic [SampleW-1:0] out_rd_q;

  always_ff @(posedge clk_i) begin
    if (rd_move) out_rd_q <= rd_q;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, lock_q, status_q, heater_q, out_rd_q};

endmodule

@@ rtl/core/ntchtp_checker.sv @@
module ntchtp_checker
  import ntchtp_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [15:0]        m_axis_tdata
);

  logic       heater_on, protecting;
  logic [1:0] status;

  assign heater_on  = m_axis_tdata[8];
  assign status     = m_axis_tdata[10:9];
  assign protecting = m_axis_tdata[11];

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // The heater never runs during the overheat lockout.
  a_lock_heater_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && protecting |-> !heater_on)
    else $error("heater on during lockout");

  a_heat_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == StHeat |-> heater_on)
    else $error("heating status with heater off");

  a_exit_unlocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == StBanExit |-> !protecting)
    else $error("ban exit while still protecting");

endmodule

bind ntc_heater_thermostat_protect_unit ntchtp_checker u_ntchtp_checker (.*);

@@ dv/ntc_heater_thermostat_protect_unit_test.sv @@
`timescale 1ns / 100ps

module ntc_heater_thermostat_protect_unit_test;
  import ntchtp_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned PhaseCount  = 9;
  localparam int unsigned PhaseWords  = 92;
  localparam int unsigned HoldCycles  = 300;

  // Indexes past the last threshold register; writes there must be ignored.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = CfgCooled + 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = CfgCooled + 3'd2;

  typedef struct packed {
    logic [3:0] pad;
    logic       protecting;
    logic [1:0] status;
    logic       heater_on;
    logic [7:0] reading;
  } reading_word_t;

  class reading_tracker;
    logic [7:0]         thresh [6];
    logic [IdxW-1:0]    pos;
    logic [7:0]         gmax;
    logic [7:0]         gmin;
    logic [SumW-1:0]    gsum;
    logic               heater;
    logic [1:0]         status;
    logic               locked;
    logic               restart;
    logic [CntW-1:0]    ticks;
    logic [CntW-1:0]    secs;
    logic [CntW-1:0]    mins;
    reading_word_t      pending_words[$];
    int unsigned        mismatch_count;

    function new();
      thresh[CfgErrorHigh] = 8'd250;
      thresh[CfgErrorLow]  = 8'd5;
      thresh[CfgHeatOn]    = 8'd150;
      thresh[CfgHeatOff]   = 8'd130;
      thresh[CfgOverheat]  = 8'd80;
      thresh[CfgCooled]    = 8'd90;
      pos = '0;
      gmax = 8'h00;
      gmin = 8'hff;
      gsum = '0;
      heater = 1'b0;
      status = StIdle;
      locked = 1'b0;
      restart = 1'b0;
      ticks = '0;
      secs = '0;
      mins = '0;
      mismatch_count = 0;
    endfunction

    function void write_threshold(logic [CfgIdxW-1:0] idx, logic [7:0] val);
      if (idx <= CfgCooled) begin
        thresh[idx] = val;
      end
    endfunction

    function void run_timer(logic [7:0] t);
      if (restart) begin
        restart = 1'b0;
        ticks = '0;
        secs = '0;
        mins = '0;
      end
      ticks = ticks + 1'b1;
      if (ticks < TicksPerSecond) return;
      ticks = '0;
      secs = secs + 1'b1;
      if (secs < SecondsPerMinute) return;
      secs = '0;
      mins = mins + 1'b1;
      if (mins < MinutesPerHour) return;
      mins = '0;
      if (t < thresh[CfgCooled]) begin
        restart = 1'b1;
      end else begin
        locked = 1'b0;
        status = StBanExit;
      end
    endfunction

    function void apply_reading(logic [7:0] t);
      // A sensor fault turns the heater off and sets the idle status, but leaves the lockout timer untouched.
      if (t > thresh[CfgErrorHigh] || t < thresh[CfgErrorLow]) begin
        heater = 1'b0;
        status = StIdle;
        return;
      end
      if (!locked) begin
        if (t > thresh[CfgHeatOn]) begin
          heater = 1'b1;
          status = StHeat;
        end
        if (t < thresh[CfgHeatOff]) begin
          heater = 1'b0;
          status = StIdle;
        end
      end
      if (t < thresh[CfgOverheat]) begin
        status = StBan;
        if (!locked) begin
          locked = 1'b1;
          restart = 1'b1;
        end
        heater = 1'b0;
      end
      if (locked) run_timer(t);
    endfunction

    function void note_sample(logic [7:0] s);
      logic [SumW-1:0] trimmed;
      logic [7:0]      t;
      reading_word_t   word;
      if (pos != '0) begin
        if (s > gmax) gmax = s;
        if (s < gmin) gmin = s;
        gsum = gsum + SumW'(s);
      end
      if (pos < LastIndex) begin
        pos = pos + 1'b1;
        return;
      end
      trimmed = gsum - SumW'(gmax) - SumW'(gmin);
      t = 8'(trimmed >> MeanShift);
      pos = '0;
      gmax = 8'h00;
      gmin = 8'hff;
      gsum = '0;
      apply_reading(t);
      word = '0;
      word.reading = t;
      word.heater_on = heater;
      word.status = status;
      word.protecting = locked;
      pending_words.push_back(word);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
        end
      end
    endfunction

    function void check_word(logic [15:0] raw);
      reading_word_t got;
      reading_word_t want;
      got = raw;
      if (pending_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: output word 0x%04h arrived with none expected", $realtime, raw);
        end
        return;
      end
      want = pending_words.pop_front();
      compare_field("reading", want.reading, got.reading);
      compare_field("heater_on", want.heater_on, got.heater_on);
      compare_field("status", want.status, got.status);
      compare_field("protecting", want.protecting, got.protecting);
      compare_field("padding", want.pad, got.pad);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [7:0]         cfg_wdata_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;   // [7:0] adc_sample
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;        // [7:0] reading, [8] heater_on,
                                           // [10:9] status, [11] protecting

  reading_tracker sb;
  int unsigned    cycle_count = 0;
  int unsigned    src_idle_pct = 0;
  int unsigned    sink_idle_pct = 0;
  int unsigned    hold_left = 0;
  int             grp_target = 0;
  int             grp_spread = 0;
  bit             grp_noise = 1'b0;

  logic [7:0] opening_samples [25] = '{
    8'h00, 8'hff, 8'h00, 8'ha0, 8'ha0, 8'ha0, 8'ha0, 8'ha0, 8'ha0, 8'ha0, 8'ha0,
    8'hff, 8'h00, 8'hff, 8'h01, 8'hfe, 8'h55, 8'haa, 8'h0f, 8'hf0, 8'h7f, 8'h80,
    8'hff, 8'hff, 8'hff
  };

  ntc_heater_thermostat_protect_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic bit idle_roll(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [7:0] clamp_sample(int v);
    if (v < 0) return 8'h00;
    if (v > 255) return 8'hff;
    return 8'(v);
  endfunction

  // Most groups cluster around a threshold or an extreme so that the readings
  // land on the decision boundaries; some are pure noise.
  function automatic logic [7:0] next_sample();
    int pick;
    pick = $urandom_range(0, 9);
    if (sb.pos == '0) begin
      grp_noise = ($urandom_range(0, 99) < 15);
      grp_spread = $urandom_range(0, 3);
      if (pick == 0) begin
        grp_target = 0;
      end else if (pick == 1) begin
        grp_target = 255;
      end else if (pick < 8) begin
        grp_target = int'(sb.thresh[$urandom_range(0, 5)]) + int'($urandom_range(0, 2)) - 1;
      end else begin
        grp_target = $urandom_range(0, 255);
      end
      return 8'($urandom_range(0, 255));
    end
    if (grp_noise) return 8'($urandom_range(0, 255));
    // An occasional outlier checks that the maximum and the minimum are trimmed.
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
    return clamp_sample(grp_target + int'($urandom_range(0, 2 * grp_spread)) - grp_spread);
  endfunction

  task automatic send_sample(input logic [7:0] s);
    while (idle_roll(src_idle_pct)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(s);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    sb.write_threshold(idx, val);
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_phase(input int p);
    logic [7:0] v [6];
    if (p == 1) begin
      v = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255};
    end else if (p == 2) begin
      v = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0};
    end else begin
      v[CfgErrorHigh] = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(170, 254));
      v[CfgErrorLow]  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 60));
      v[CfgHeatOn]    = 8'($urandom_range(60, 220));
      v[CfgHeatOff]   = 8'($urandom_range(40, 200));
      v[CfgCooled]    = 8'($urandom_range(0, 255));
      // Lockout never clears within the run, so it is only enabled in the last two phases.
      if (p == 8) v[CfgOverheat] = 8'd255;
      else if (p == 7) v[CfgOverheat] = 8'($urandom_range(60, 120));
      else v[CfgOverheat] = 8'd0;
    end
    for (int i = 0; i < 6; i++) begin
      write_reg(CfgIdxW'(i), v[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Output side: takes words, idles at random and honors a long hold-off.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !idle_roll(sink_idle_pct);
      end
    end
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 20;
    sink_idle_pct = 75;
    write_reg(CfgSpareLo, 8'($urandom_range(0, 255)));
    write_reg(CfgSpareHi, 8'($urandom_range(0, 255)));
    cfg_we_i <= 1'b0;
    foreach (opening_samples[i]) begin
      send_sample(opening_samples[i]);
    end
    drain();

    for (int p = 0; p < PhaseCount; p++) begin
      if (p / 3 == 0) begin
        src_idle_pct = 20;
        sink_idle_pct = 75;
      end else if (p / 3 == 1) begin
        src_idle_pct = 75;
        sink_idle_pct = 20;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      program_phase(p);
      // Full rate input against a stalled output fills the block up.
      if (p == 6) hold_left = HoldCycles;
      for (int n = 0; n < PhaseWords; n++) begin
        send_sample(next_sample());
      end
      drain();
    end

    if (sb.mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
